/* rtl/ssdc_pkg.sv */
// Shared types and constants for the strided slice dimension canonicalizer.
// Used by the canonicalization front end, the divider and the top level.
package ssdc_pkg;

  localparam int INDEX_WIDTH = 32;
  localparam int DIM_WIDTH   = INDEX_WIDTH - 1;
  // two guard bits so that extent plus index and their differences never wrap
  localparam int CALC_WIDTH  = INDEX_WIDTH + 2;
  localparam int MAG_WIDTH   = INDEX_WIDTH;
  localparam int QUO_WIDTH   = DIM_WIDTH;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_ZERO_STRIDE   = 2'd1,
    ERR_SHRINK_STRIDE = 2'd2,
    ERR_SHRINK_RANGE  = 2'd3
  } err_t;

  typedef logic signed [INDEX_WIDTH-1:0] index_t;
  typedef logic signed [CALC_WIDTH-1:0]  calc_t;

  typedef struct packed {
    logic [DIM_WIDTH-1:0] extent;
    logic                 dim_known;
    index_t               begin_index;
    index_t               end_index;
    index_t               stride;
    logic                 begin_masked;
    logic                 end_masked;
    logic                 shrink;
    logic                 is_first_dim;
  } in_t;

  typedef struct packed {
    index_t out_begin;
    index_t out_end;
    index_t slice_size;
    logic   identity_ok;
    logic   simple_ok;
    logic   dim0_ok;
    err_t   error_code;
  } out_t;

  // result fields that ride along the divider untouched
  typedef struct packed {
    index_t out_begin;
    index_t out_end;
    logic   identity_ok;
    logic   simple_ok;
    logic   dim0_ok;
    err_t   error_code;
    logic   size_unknown;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [QUO_WIDTH-1:0] dividend;
    logic [MAG_WIDTH-1:0] divisor;
  } div_in_t;

  typedef struct packed {
    side_t                side;
    logic [QUO_WIDTH-1:0] quotient;
    logic                 rem_nz;
  } div_out_t;

endpackage

/* rtl/ssdc_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Payload types come from ssdc_pkg.
interface ssdc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/strided_slice_dim_canonicalizer.sv */
// Top level of the strided slice dimension canonicalizer: configuration register,
// front end, divider and output register. Depends on ssdc_pkg, ssdc_stream_if and submodules.
//
// Usage:
//   din  carries one dense slice dimension per transfer (ssdc_pkg::in_t).
//   dout carries one result per input (ssdc_pkg::out_t), in input order.
//   cfg  writes the one-bit bounds_known register; it is always ready and
//        should be written only while no dimension is in flight.
// Each dimension passes 35 registers: three of canonicalization, 31 divider
// stages (one quotient bit each, sized by the 31-bit dividend) and the output
// register. Throughput is one dimension per cycle with dout.ready held high.
// Reset clears every valid bit and sets bounds_known to 1.
// When the receiver stalls, the output register holds its result. The front end
// and the divider each advance as a whole while their last stage is empty or
// taken downstream; once the output register and the last stages of both hold
// results that are not taken, din.ready falls and every stage holds in place.
module strided_slice_dim_canonicalizer (
  input  logic          clk,
  input  logic          rst,
  ssdc_stream_if.sink   din,
  ssdc_stream_if.source dout,
  ssdc_stream_if.sink   cfg
);

  localparam int IW = ssdc_pkg::INDEX_WIDTH;

  ssdc_stream_if #(.payload_t(ssdc_pkg::div_in_t))  canon_to_div ();
  ssdc_stream_if #(.payload_t(ssdc_pkg::div_out_t)) div_to_out ();

  logic            bounds_known;
  logic            ov;
  ssdc_pkg::out_t  opay;
  ssdc_pkg::out_t  opay_next;
  logic            oadv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds_known <= 1'b1;
    end else if (cfg.valid) begin
      bounds_known <= cfg.payload;
    end
  end

  ssdc_canon u_canon (
    .clk          (clk),
    .rst          (rst),
    .bounds_known (bounds_known),
    .up           (din),
    .dn           (canon_to_div)
  );

  ssdc_div u_div (
    .clk (clk),
    .rst (rst),
    .up  (canon_to_div),
    .dn  (div_to_out)
  );

  // round the quotient up and format the result
  always_comb begin
    ssdc_pkg::div_out_t d;
    d = div_to_out.payload;
    opay_next.out_begin   = d.side.out_begin;
    opay_next.out_end     = d.side.out_end;
    opay_next.identity_ok = d.side.identity_ok;
    opay_next.simple_ok   = d.side.simple_ok;
    opay_next.dim0_ok     = d.side.dim0_ok;
    opay_next.error_code  = d.side.error_code;
    if (d.side.size_unknown) opay_next.slice_size = '1;
    else opay_next.slice_size = {{(IW-ssdc_pkg::QUO_WIDTH){1'b0}}, d.quotient}
                                + IW'(d.rem_nz);
  end

  assign oadv             = !ov || dout.ready;
  assign div_to_out.ready = oadv;
  assign dout.valid       = ov;
  assign dout.payload     = opay;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (oadv) begin
      ov <= div_to_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oadv) begin
      opay <= opay_next;
    end
  end

endmodule

/* rtl/ssdc_canon.sv */
// Three-stage front end: wraps negative indices, clamps and resolves masks, then
// forms the divider operands and the flag fields. Depends on ssdc_pkg and ssdc_stream_if.
module ssdc_canon (
  input  logic          clk,
  input  logic          rst,
  input  logic          bounds_known,
  ssdc_stream_if.sink   up,
  ssdc_stream_if.source dn
);

  typedef struct packed {
    ssdc_pkg::in_t   item;
    ssdc_pkg::calc_t dim;
    ssdc_pkg::calc_t fb;
    ssdc_pkg::calc_t fe;
    logic            bounds_known;
    ssdc_pkg::err_t  err;
  } s1_t;

  typedef struct packed {
    ssdc_pkg::in_t   item;
    ssdc_pkg::calc_t dim;
    ssdc_pkg::calc_t ob;
    ssdc_pkg::calc_t oe;
    logic            bounds_known;
    ssdc_pkg::err_t  err;
  } s2_t;

  localparam int CW = ssdc_pkg::CALC_WIDTH;
  localparam int IW = ssdc_pkg::INDEX_WIDTH;

  function automatic ssdc_pkg::calc_t clamp(ssdc_pkg::calc_t x, ssdc_pkg::calc_t lo,
                                            ssdc_pkg::calc_t hi);
    ssdc_pkg::calc_t r;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    else r = x;
    return r;
  endfunction

  logic v1, v2, v3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  ssdc_pkg::div_in_t s3, s3_next;
  logic adv;

  assign adv        = !v3 || dn.ready;
  assign up.ready   = adv;
  assign dn.valid   = v3;
  assign dn.payload = s3;

  // stage 1: wrap negative begin and end, flag a zero stride or a negative shrink stride
  always_comb begin
    ssdc_pkg::in_t   it;
    ssdc_pkg::calc_t bi;
    ssdc_pkg::calc_t ei;
    it = up.payload;
    bi = {{(CW-IW){it.begin_index[IW-1]}}, it.begin_index};
    ei = {{(CW-IW){it.end_index[IW-1]}}, it.end_index};
    s1_next.item         = it;
    s1_next.dim          = {{(CW-ssdc_pkg::DIM_WIDTH){1'b0}}, it.extent};
    s1_next.fb           = bi[CW-1] ? s1_next.dim + bi : bi;
    s1_next.fe           = ei[CW-1] ? s1_next.dim + ei : ei;
    s1_next.bounds_known = bounds_known;
    if (it.stride == '0) s1_next.err = ssdc_pkg::ERR_ZERO_STRIDE;
    else if (it.dim_known && it.shrink && it.stride[IW-1])
      s1_next.err = ssdc_pkg::ERR_SHRINK_STRIDE;
    else s1_next.err = ssdc_pkg::ERR_NONE;
  end

  // stage 2: clamp to the range of the stride's direction, resolve masks, check shrink index
  always_comb begin
    logic            st_neg;
    ssdc_pkg::calc_t lo;
    ssdc_pkg::calc_t hi;
    logic            range_bad;
    st_neg    = s1.item.stride[IW-1];
    lo        = {CW{st_neg}};
    hi        = st_neg ? s1.dim - CW'(1) : s1.dim;
    range_bad = s1.fb[CW-1] || (s1.fb >= s1.dim);
    s2_next.item         = s1.item;
    s2_next.dim          = s1.dim;
    s2_next.bounds_known = s1.bounds_known;
    if (s1.item.shrink) begin
      s2_next.ob = s1.fb;
      s2_next.oe = s1.fb + CW'(1);
    end else begin
      s2_next.ob = s1.item.begin_masked ? (st_neg ? hi : lo) : clamp(s1.fb, lo, hi);
      s2_next.oe = s1.item.end_masked ? (st_neg ? lo : hi) : clamp(s1.fe, lo, hi);
    end
    if (s1.err == ssdc_pkg::ERR_NONE && s1.item.dim_known && s1.bounds_known &&
        s1.item.shrink && range_bad)
      s2_next.err = ssdc_pkg::ERR_SHRINK_RANGE;
    else s2_next.err = s1.err;
  end

  // stage 3: flags, interval and divider operands
  always_comb begin
    logic            st_neg;
    logic            st1;
    logic            both;
    logic            all_taken;
    logic            have_ival;
    ssdc_pkg::calc_t ival;
    ssdc_pkg::calc_t ival_mag;
    logic [ssdc_pkg::MAG_WIDTH-1:0] st_mag;
    st_neg    = s2.item.stride[IW-1];
    st1       = (s2.item.stride == ssdc_pkg::index_t'(1));
    both      = s2.item.begin_masked && s2.item.end_masked;
    all_taken = st1 && (s2.ob == '0) && (s2.oe == s2.dim);
    st_mag    = st_neg ? (~s2.item.stride + 1'b1) : s2.item.stride;
    have_ival = 1'b0;
    ival      = '0;
    ival_mag  = '0;

    s3_next.side.out_begin    = s2.item.begin_index;
    s3_next.side.out_end      = s2.item.end_index;
    s3_next.side.identity_ok  = 1'b1;
    s3_next.side.simple_ok    = 1'b1;
    s3_next.side.dim0_ok      = 1'b1;
    s3_next.side.error_code   = s2.err;
    s3_next.side.size_unknown = 1'b0;
    s3_next.dividend          = '0;
    s3_next.divisor           = ssdc_pkg::MAG_WIDTH'(1);

    if (s2.err != ssdc_pkg::ERR_NONE) begin
      s3_next.side.identity_ok = 1'b0;
      s3_next.side.simple_ok   = 1'b0;
      s3_next.side.dim0_ok     = 1'b0;
    end else if (!s2.item.dim_known) begin
      // extent unknown: size is one for a shrink, else unknown
      s3_next.side.size_unknown = !s2.item.shrink;
      s3_next.dividend          = ssdc_pkg::QUO_WIDTH'(s2.item.shrink);
    end else begin
      s3_next.side.simple_ok = st1;
      if (s2.bounds_known) begin
        s3_next.side.out_begin   = s2.ob[IW-1:0];
        s3_next.side.out_end     = s2.oe[IW-1:0];
        s3_next.side.identity_ok = all_taken;
        s3_next.side.dim0_ok     = (s2.item.is_first_dim && st1) || all_taken;
        ival                     = s2.oe - s2.ob;
        have_ival                = 1'b1;
      end else begin
        s3_next.side.identity_ok = st1 && both;
        s3_next.side.dim0_ok     = (s2.item.is_first_dim && st1) || both;
        if (s2.item.shrink) begin
          ival      = CW'(1);
          have_ival = 1'b1;
        end else if (both) begin
          ival      = st_neg ? -s2.dim : s2.dim;
          have_ival = 1'b1;
        end else begin
          s3_next.side.size_unknown = 1'b1;
        end
      end
      // an interval pointing against the stride leaves the dividend at zero
      if (have_ival && ival != '0 && (ival[CW-1] == st_neg)) begin
        ival_mag         = ival[CW-1] ? -ival : ival;
        s3_next.dividend = ival_mag[ssdc_pkg::QUO_WIDTH-1:0];
        s3_next.divisor  = st_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= up.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

endmodule

/* rtl/ssdc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, carrying side fields along.
// Depends on ssdc_pkg and ssdc_stream_if.
module ssdc_div (
  input  logic          clk,
  input  logic          rst,
  ssdc_stream_if.sink   up,
  ssdc_stream_if.source dn
);

  localparam int STEPS = ssdc_pkg::QUO_WIDTH;
  localparam int MW    = ssdc_pkg::MAG_WIDTH;

  // work starts as the dividend and fills with quotient bits from the bottom
  typedef struct packed {
    ssdc_pkg::side_t  side;
    logic [STEPS-1:0] work;
    logic [MW-1:0]    divisor;
    logic [MW-1:0]    rem;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t  r;
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;
    r     = s;
    trial = {s.rem, s.work[STEPS-1]};
    diff  = trial - {1'b0, s.divisor};
    ge    = (trial >= {1'b0, s.divisor});
    r.rem  = ge ? diff[MW-1:0] : trial[MW-1:0];
    r.work = {s.work[STEPS-2:0], ge};
    return r;
  endfunction

  logic [STEPS-1:0] vld;
  div_stage_t       stage [STEPS];
  div_stage_t       init;
  logic             adv;

  assign adv = !vld[STEPS-1] || dn.ready;
  assign up.ready = adv;
  assign dn.valid = vld[STEPS-1];
  assign dn.payload.side     = stage[STEPS-1].side;
  assign dn.payload.quotient = stage[STEPS-1].work;
  assign dn.payload.rem_nz   = (stage[STEPS-1].rem != '0);

  always_comb begin
    init.side    = up.payload.side;
    init.work    = up.payload.dividend;
    init.divisor = up.payload.divisor;
    init.rem     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STEPS-2:0], up.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage[0] <= div_step(init);
      for (int k = 1; k < STEPS; k++) begin
        stage[k] <= div_step(stage[k-1]);
      end
    end
  end

endmodule
